// File: rtl/kagf_pkg.sv
package kagf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC           = 30;    // fraction bits of covariances and gains
  localparam int CFG_W          = 31;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 31'd21474836;
  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST   = 31'd10737418;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST    = 31'd322123;
  localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = 31'd10737418;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd3;

  // micro-op codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // operand / destination codes
  localparam logic [3:0] R_ANGLE = 4'd0;
  localparam logic [3:0] R_BIAS  = 4'd1;
  localparam logic [3:0] R_C00   = 4'd2;
  localparam logic [3:0] R_C01   = 4'd3;
  localparam logic [3:0] R_C10   = 4'd4;
  localparam logic [3:0] R_C11   = 4'd5;
  localparam logic [3:0] R_ACC   = 4'd6;
  localparam logic [3:0] R_GYRO  = 4'd7;
  localparam logic [3:0] R_DT    = 4'd8;
  localparam logic [3:0] R_AN    = 4'd9;
  localparam logic [3:0] R_BN    = 4'd10;
  localparam logic [3:0] R_MN    = 4'd11;
  localparam logic [3:0] R_T     = 4'd12;
  localparam logic [3:0] R_U     = 4'd13;
  localparam logic [3:0] R_K0    = 4'd14;
  localparam logic [3:0] R_K1    = 4'd15;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic [3:0] dst;
  } step_t;

  localparam int PROG_LEN = 29;
  localparam int PC_W     = $clog2(PROG_LEN);

  // one sample: predict, gains, then correction in order
  localparam step_t PROG [PROG_LEN] = '{
    '{OP_SUB, R_GYRO,  R_BIAS,  R_T    },  // rate minus bias
    '{OP_MUL, R_DT,    R_T,     R_U    },
    '{OP_ADD, R_ANGLE, R_U,     R_ANGLE},
    '{OP_ADD, R_C10,   R_C01,   R_T    },
    '{OP_MUL, R_AN,    R_DT,    R_U    },
    '{OP_MUL, R_DT,    R_T,     R_T    },
    '{OP_SUB, R_U,     R_T,     R_T    },
    '{OP_ADD, R_C00,   R_T,     R_C00  },
    '{OP_MUL, R_DT,    R_C11,   R_T    },
    '{OP_SUB, R_C01,   R_T,     R_C01  },
    '{OP_SUB, R_C10,   R_T,     R_C10  },
    '{OP_MUL, R_BN,    R_DT,    R_T    },
    '{OP_ADD, R_C11,   R_T,     R_C11  },
    '{OP_SUB, R_ACC,   R_ANGLE, R_T    },  // innovation held in T from here
    '{OP_ADD, R_C00,   R_MN,    R_U    },  // denominator
    '{OP_DIV, R_C00,   R_U,     R_K0   },
    '{OP_DIV, R_C10,   R_U,     R_K1   },
    '{OP_MUL, R_K0,    R_T,     R_U    },
    '{OP_ADD, R_ANGLE, R_U,     R_ANGLE},
    '{OP_MUL, R_K1,    R_T,     R_U    },
    '{OP_ADD, R_BIAS,  R_U,     R_BIAS },
    '{OP_MUL, R_K0,    R_C00,   R_U    },
    '{OP_SUB, R_C00,   R_U,     R_C00  },
    '{OP_MUL, R_K0,    R_C01,   R_U    },
    '{OP_SUB, R_C01,   R_U,     R_C01  },
    '{OP_MUL, R_K1,    R_C00,   R_U    },
    '{OP_SUB, R_C10,   R_U,     R_C10  },
    '{OP_MUL, R_K1,    R_C01,   R_U    },
    '{OP_SUB, R_C11,   R_U,     R_C11  }
  };

endpackage

// File: rtl/kagf_mul.sv
module kagf_mul #(
  parameter int W   = kagf_pkg::DATA_WIDTH_DEF,
  parameter int OPW = (W > 32) ? W : 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [OPW-1:0] a,
  input  logic signed [OPW-1:0] b,
  output logic signed [W-1:0]   result,
  output logic                done
);
  import kagf_pkg::*;

  localparam int HW = (OPW + 1) / 2;
  localparam int PW = OPW + HW;
  localparam int AW = 2 * OPW + 1;
  localparam int MW = AW - FRAC;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_RND  = 2'd3;

  localparam logic [AW-1:0]     RND  = AW'(1) << (FRAC - 1);
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [1:0]     ph_r;
  logic           done_r;
  logic [OPW-1:0] ma_r, mb_r;
  logic           neg_r;
  logic [AW-1:0]  acc_r;
  logic signed [W-1:0] res_r;

  logic [HW-1:0]  half;
  logic [PW-1:0]  prod;
  logic [MW-1:0]  mag_w;
  logic           ovf;
  logic signed [W-1:0] sat_val;

  // one OPW x HW multiplier, used for the low then the high half of b
  always_comb begin
    half = (ph_r == PH_LO) ? mb_r[HW-1:0] : HW'(mb_r[OPW-1:HW]);
    prod = PW'(ma_r) * PW'(half);
  end

  // magnitude is rounded, then saturated with the sign
  always_comb begin
    mag_w = acc_r[AW-1:FRAC];
    ovf   = (|mag_w[MW-1:W]) | (mag_w[W-1] & (~neg_r | (|mag_w[W-2:0])));
    if (ovf) begin
      sat_val = neg_r ? MINV : MAXV;
    end else begin
      sat_val = neg_r ? -$signed(mag_w[W-1:0]) : $signed(mag_w[W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: if (start) ph_r <= PH_LO;
        PH_LO:   ph_r <= PH_HI;
        PH_HI:   ph_r <= PH_RND;
        PH_RND: begin
          ph_r   <= PH_IDLE;
          done_r <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == PH_IDLE && start) begin
      ma_r  <= a[OPW-1] ? (~a + 1'b1) : a;
      mb_r  <= b[OPW-1] ? (~b + 1'b1) : b;
      neg_r <= a[OPW-1] ^ b[OPW-1];
    end
    if (ph_r == PH_LO) acc_r <= AW'(prod) + RND;
    if (ph_r == PH_HI) acc_r <= acc_r + (AW'(prod) << HW);
    if (ph_r == PH_RND) res_r <= sat_val;
  end

  assign result = res_r;
  assign done   = done_r;

endmodule

// File: rtl/kagf_div.sv
module kagf_div #(
  parameter int W = kagf_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic signed [W-1:0] result,
  output logic                done
);
  import kagf_pkg::*;

  localparam int NB   = W + FRAC;
  localparam int ITER = (NB + 1) / 2;   // two quotient bits a cycle
  localparam int DVW  = 2 * ITER;
  localparam int CW   = $clog2(ITER + 1);

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic           busy_r, done_r;
  logic [CW-1:0]  cnt_r;
  logic [DVW-1:0] dv_r;
  logic [W-1:0]   rem_r, ud_r;
  logic [W:0]     q_r;
  logic           ovf_r, neg_r;
  logic signed [W-1:0] res_r;

  logic [W-1:0]   un, ud;
  logic [W:0]     r2;
  logic [W-1:0]   rem_s;
  logic [W:0]     q_s;
  logic           ovf_s, q_ovf;
  logic signed [W-1:0] sat_val;

  always_comb begin
    un = num[W-1] ? (~num + 1'b1) : num;
    ud = den[W-1] ? (~den + 1'b1) : den;
  end

  // two restoring steps; bits pushed out of the quotient top are sticky
  always_comb begin
    rem_s = rem_r;
    q_s   = q_r;
    ovf_s = ovf_r;
    r2    = '0;
    for (int j = 0; j < 2; j++) begin
      r2    = {rem_s, dv_r[DVW-1-j]};
      ovf_s = ovf_s | q_s[W];
      q_s   = q_s << 1;
      if (r2 >= {1'b0, ud_r}) begin
        r2     = r2 - {1'b0, ud_r};
        q_s[0] = 1'b1;
      end
      rem_s = r2[W-1:0];
    end
    q_ovf = ovf_s | q_s[W] | (q_s[W-1] & (~neg_r | (|q_s[W-2:0])));
    if (q_ovf) begin
      sat_val = neg_r ? MINV : MAXV;
    end else begin
      sat_val = neg_r ? -$signed(q_s[W-1:0]) : $signed(q_s[W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && start) begin
        if (den == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(ITER);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      dv_r  <= DVW'(un) << FRAC;
      ud_r  <= ud;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      neg_r <= num[W-1] ^ den[W-1];
      res_r <= '0;
    end else if (busy_r) begin
      dv_r  <= dv_r << 2;
      rem_r <= rem_s;
      q_r   <= q_s;
      ovf_r <= ovf_s;
      if (cnt_r == CW'(1)) res_r <= sat_val;
    end
  end

  assign result = res_r;
  assign done   = done_r;

endmodule

// File: rtl/kalman_angle_gyro_fusion.sv
// Two-state angle / gyro-bias Kalman filter.
// Input channel (in_valid / in_stall): one item carries an accelerometer angle
// and a gyro rate, both Q16.16. in_stall is high while an item is being worked.
// Output channel (out_valid / out_stall): one item per input, the new angle in
// Q16.16, held in an output register until taken.
// Config port (cfg_valid / cfg_ready, always ready): cfg_index selects sample
// period, angle noise, bias noise or measurement noise; the low 31 bits of
// cfg_data are kept. Write only while the filter is idle.
// A small sequencer runs 29 micro-ops through one adder, one multiplier
// (half-width partial products) and one radix-2 divider (two quotient
// bits a cycle). A zero denominator ends a divide without iterating, with a
// zero result. A new item is taken the cycle after the result is loaded into
// the output register. If the previous result is still stalled, the finished
// item waits for it.
// Reset (rst_n, synchronous, active low) clears angle, bias and covariance and
// loads the default noise and period values.
module kalman_angle_gyro_fusion #(
  parameter int DATA_WIDTH = kagf_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kagf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                in_acc_angle,
  input  logic signed [31:0]                in_gyro_rate,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_angle_estimate
);
  import kagf_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int OPW = (W > 32) ? W : 32;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic signed [OPW:0] ONE  = 1;
  localparam logic signed [OPW:0] SMAX = (ONE <<< (W - 1)) - ONE;
  localparam logic signed [OPW:0] SMIN = -SMAX - ONE;

  logic [1:0]      state_r;
  logic [PC_W-1:0] pc_r;
  logic signed [W-1:0] angle_r, bias_r, c00_r, c01_r, c10_r, c11_r;
  logic signed [W-1:0] t_r, u_r, k0_r, k1_r, meas_r, gyro_r;
  logic [CFG_W-1:0] sample_period_r, angle_noise_r, bias_noise_r, measure_noise_r;
  logic             out_valid_r;
  logic signed [31:0] out_angle_r;

  step_t step;
  logic  last;
  logic signed [OPW-1:0] op_a, op_b, angle_x;
  logic signed [OPW:0]   sum;
  logic signed [W-1:0]   alu_res, mul_res, div_res, wr_val;
  logic  wr_en, mul_start, div_start, mul_done, div_done, in_acc, fin_go;

  function automatic logic signed [W-1:0] sat_w(input logic signed [OPW:0] v);
    logic signed [W-1:0] r;
    if (v > SMAX) begin
      r = W'(SMAX);
    end else if (v < SMIN) begin
      r = W'(SMIN);
    end else begin
      r = W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [OPW-1:0] opnd(input logic [3:0] code);
    logic signed [OPW-1:0] r;
    unique case (code)
      R_ANGLE: r = OPW'(angle_r);
      R_BIAS:  r = OPW'(bias_r);
      R_C00:   r = OPW'(c00_r);
      R_C01:   r = OPW'(c01_r);
      R_C10:   r = OPW'(c10_r);
      R_C11:   r = OPW'(c11_r);
      R_ACC:   r = OPW'(meas_r);
      R_GYRO:  r = OPW'(gyro_r);
      R_DT:    r = OPW'(sample_period_r);
      R_AN:    r = OPW'(angle_noise_r);
      R_BN:    r = OPW'(bias_noise_r);
      R_MN:    r = OPW'(measure_noise_r);
      R_T:     r = OPW'(t_r);
      R_U:     r = OPW'(u_r);
      R_K0:    r = OPW'(k0_r);
      R_K1:    r = OPW'(k1_r);
    endcase
    return r;
  endfunction

  always_comb begin
    step    = PROG[pc_r];
    last    = (pc_r == PC_W'(PROG_LEN - 1));
    op_a    = opnd(step.src_a);
    op_b    = opnd(step.src_b);
    sum     = (step.op == OP_SUB) ? ((OPW+1)'(op_a) - (OPW+1)'(op_b))
                                  : ((OPW+1)'(op_a) + (OPW+1)'(op_b));
    alu_res = sat_w(sum);
    angle_x = OPW'(angle_r);

    mul_start = (state_r == S_ISSUE) && (step.op == OP_MUL);
    div_start = (state_r == S_ISSUE) && (step.op == OP_DIV);
    in_acc    = (state_r == S_IDLE) && in_valid;
    fin_go    = (state_r == S_FIN) && (!out_valid_r || !out_stall);

    wr_en  = 1'b0;
    wr_val = alu_res;
    if (state_r == S_ISSUE && (step.op == OP_ADD || step.op == OP_SUB)) begin
      wr_en = 1'b1;
    end else if (state_r == S_WAIT && mul_done) begin
      wr_en  = 1'b1;
      wr_val = mul_res;
    end else if (state_r == S_WAIT && div_done) begin
      wr_en  = 1'b1;
      wr_val = div_res;
    end
  end

  kagf_mul #(.W(W), .OPW(OPW)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (op_a),
    .b      (op_b),
    .result (mul_res),
    .done   (mul_done)
  );

  kagf_div #(.W(W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (op_a[W-1:0]),
    .den    (op_b[W-1:0]),
    .result (div_res),
    .done   (div_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_ISSUE;
            pc_r    <= '0;
          end
        end
        S_ISSUE: begin
          if (step.op == OP_MUL || step.op == OP_DIV) begin
            state_r <= S_WAIT;
          end else if (last) begin
            state_r <= S_FIN;
          end else begin
            pc_r <= pc_r + 1'b1;
          end
        end
        S_WAIT: begin
          if (mul_done || div_done) begin
            if (last) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_ISSUE;
              pc_r    <= pc_r + 1'b1;
            end
          end
        end
        S_FIN: if (fin_go) state_r <= S_IDLE;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r  <= '0;
      c00_r   <= '0;
      c01_r   <= '0;
      c10_r   <= '0;
      c11_r   <= '0;
    end else if (wr_en) begin
      case (step.dst)
        R_ANGLE: angle_r <= wr_val;
        R_BIAS:  bias_r  <= wr_val;
        R_C00:   c00_r   <= wr_val;
        R_C01:   c01_r   <= wr_val;
        R_C10:   c10_r   <= wr_val;
        R_C11:   c11_r   <= wr_val;
        default: ;
      endcase
    end
  end

  // scratch and captured item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r <= sat_w((OPW+1)'(in_acc_angle));
      gyro_r <= sat_w((OPW+1)'(in_gyro_rate));
    end
    if (wr_en) begin
      case (step.dst)
        R_T:     t_r  <= wr_val;
        R_U:     u_r  <= wr_val;
        R_K0:    k0_r <= wr_val;
        R_K1:    k1_r <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= SAMPLE_PERIOD_RST;
      angle_noise_r   <= ANGLE_NOISE_RST;
      bias_noise_r    <= BIAS_NOISE_RST;
      measure_noise_r <= MEASURE_NOISE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAMPLE_PERIOD: sample_period_r <= cfg_data[CFG_W-1:0];
        CFG_ANGLE_NOISE:   angle_noise_r   <= cfg_data[CFG_W-1:0];
        CFG_BIAS_NOISE:    bias_noise_r    <= cfg_data[CFG_W-1:0];
        CFG_MEASURE_NOISE: measure_noise_r <= cfg_data[CFG_W-1:0];
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) out_angle_r <= angle_x[31:0];
  end

  assign cfg_ready          = 1'b1;
  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_angle_estimate = out_angle_r;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ISSUE && pc_r == '0))
    else $error("accepted item did not start at the first step");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_done || div_done) |-> (state_r == S_WAIT))
    else $error("unit finished while sequencer not waiting");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (pc_r <= PC_W'(PROG_LEN - 1)))
    else $error("step counter past end of program");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result presented without finishing the sequence");

  a_wait_needs_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && $past(state_r) == S_ISSUE)
      |-> ($past(step.op) == OP_MUL || $past(step.op) == OP_DIV))
    else $error("waiting without a multi-cycle op issued");
`endif

endmodule
